// File: rtl/core/i2cem_pkg.sv
// Package for the I2C EEPROM master sequencer: result item type and
// configuration register indexes. No dependencies.

package i2cem_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgPhaseTicks    = 2'd0;
  localparam logic [1:0] CfgAckPollLimit  = 2'd1;
  localparam logic [1:0] CfgWriteWait     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0]  PhaseTicksRst   = 8'd2;
  localparam logic [7:0]  AckPollLimitRst = 8'd250;
  localparam logic [15:0] WriteWaitRst    = 16'd5000;

  // One result item, as produced for every accepted tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_listen;
    logic       busy_res;
    logic       byte_taken;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic       done_res;
  } result_t;

endpackage

// File: rtl/core/i2cem_skid.sv
// Two-entry output buffer for result items of the I2C EEPROM master
// sequencer. Depends on i2cem_pkg for the result item type.

module i2cem_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2cem_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output i2cem_pkg::result_t data_o
);
  import i2cem_pkg::*;

  logic    out_vld_q, skid_vld_q;
  result_t out_q, skid_q;
  logic    out_fire;

  assign out_fire = out_vld_q & ready_i;
  assign ready_o  = ~skid_vld_q;
  assign valid_o  = out_vld_q;
  assign data_o   = out_q;

  // Valid flags: the skid entry fills only when the output entry is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q || out_fire) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  // Payload entries carry no reset.
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_vld_q || out_fire) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

endmodule

// File: rtl/core/i2c_eeprom_master_sequencer.sv
// I2C EEPROM master sequencer, top level. Depends on i2cem_pkg and i2cem_skid.
// The result item for a tick is registered in the output buffer when the tick
// item is accepted. Throughput: one item per cycle unless the buffer is full,
// set by the single step of the sequencer state machine and a two-entry buffer.
// Reset (asynchronous, active low) returns the sequencer to idle, clears its
// counters and loads the configuration registers with their default values.

module i2c_eeprom_master_sequencer #(
  parameter int MAX_BURST = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // Tick item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_valid_i,
  input  logic        req_type_i,
  input  logic [7:0]  dev_sel_i,
  input  logic [7:0]  word_addr_i,
  input  logic [8:0]  byte_count_i,
  input  logic [7:0]  wr_data_i,
  input  logic        sda_in_i,
  // Result item channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_level_o,
  output logic        sda_level_o,
  output logic        sda_listen_o,
  output logic        busy_res_o,
  output logic        byte_taken_o,
  output logic [7:0]  rd_data_o,
  output logic        rd_valid_o,
  output logic        rd_last_o,
  output logic        done_res_o
);
  import i2cem_pkg::*;

  localparam int         CntW   = $clog2(MAX_BURST + 1);
  localparam logic [8:0] MaxCnt = 9'(MAX_BURST);

  typedef enum logic [3:0] {
    StIdle, StStc, StSth, StStl, StWbl, StWbh, StAkl, StAkh,
    StRbl, StRbh, StMal, StMah, StSpa, StSpb, StSpc, StWait
  } state_e;

  typedef enum logic [2:0] {
    GDev, GAddr, GData, GRdev, GRead
  } stage_e;

  // Configuration registers
  logic [7:0]  phase_ticks_q, ack_limit_q;
  logic [15:0] wait_ticks_q;

  // Sequencer state
  state_e          seq_q, seq_d;
  stage_e          stage_q, stage_d;
  logic [7:0]      phase_q, phase_d;
  logic [3:0]      bit_q, bit_d;
  logic [7:0]      shift_q, shift_d;
  logic [CntW-1:0] left_q, left_d;
  logic [CntW-1:0] orig_q, orig_d;
  logic [7:0]      poll_q, poll_d;
  logic [15:0]     wait_q, wait_d;
  logic            rtype_q, rtype_d;
  logic [7:0]      dev_q, dev_d;
  logic [7:0]      addr_q, addr_d;
  logic            restart_q, restart_d;

  // Step signals
  logic            acc;
  logic [7:0]      pt;
  logic [8:0]      phase_inc;
  logic            phase_last;
  logic            end_phase;
  logic [8:0]      cnt_c;
  logic [CntW-1:0] left_dec;
  logic [15:0]     wait_inc;
  logic            taken, rdv, rdl, done;
  logic            mack;
  result_t         res_d, res_q;
  logic            skid_ready;

  assign acc        = in_valid_i & in_ready_o;
  assign in_ready_o = skid_ready;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksRst;
      ack_limit_q   <= AckPollLimitRst;
      wait_ticks_q  <= WriteWaitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPhaseTicks:   phase_ticks_q <= cfg_wdata_i[7:0];
        CfgAckPollLimit: ack_limit_q   <= cfg_wdata_i[7:0];
        CfgWriteWait:    wait_ticks_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Phase timing: a zero phase length behaves as one tick.
  assign pt         = (phase_ticks_q == 8'd0) ? 8'd1 : phase_ticks_q;
  assign phase_inc  = {1'b0, phase_q} + 9'd1;
  assign phase_last = (phase_inc >= {1'b0, pt});
  assign end_phase  = (seq_q != StIdle) && (seq_q != StWait) && (seq_q != StAkh)
                      && phase_last;
  assign left_dec   = (left_q != '0) ? left_q - CntW'(1) : '0;
  assign wait_inc   = wait_q + 16'd1;

  // Requested count clamped to one through the burst limit.
  always_comb begin
    cnt_c = (byte_count_i == 9'd0) ? 9'd1 : byte_count_i;
    if (cnt_c > MaxCnt) begin
      cnt_c = MaxCnt;
    end
  end

  // One sequencer step for each accepted tick.
  always_comb begin
    seq_d     = seq_q;
    stage_d   = stage_q;
    phase_d   = phase_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    left_d    = left_q;
    orig_d    = orig_q;
    poll_d    = poll_q;
    wait_d    = wait_q;
    rtype_d   = rtype_q;
    dev_d     = dev_q;
    addr_d    = addr_q;
    restart_d = restart_q;
    taken     = 1'b0;
    rdv       = 1'b0;
    rdl       = 1'b0;
    done      = 1'b0;
    if (acc) begin
      if (seq_q != StIdle && seq_q != StWait && seq_q != StAkh) begin
        phase_d = phase_last ? 8'd0 : phase_inc[7:0];
      end
      unique case (seq_q)
        StIdle: begin
          if (req_valid_i) begin
            rtype_d   = req_type_i;
            dev_d     = dev_sel_i;
            addr_d    = word_addr_i;
            orig_d    = CntW'(cnt_c);
            left_d    = CntW'(cnt_c);
            stage_d   = GDev;
            restart_d = 1'b0;
            phase_d   = 8'd0;
            poll_d    = 8'd0;
            bit_d     = 4'd0;
            seq_d     = StStc;
          end
        end
        StStc: if (end_phase) seq_d = StSth;
        StSth: if (end_phase) seq_d = StStl;
        StStl: begin
          if (end_phase) begin
            shift_d = (stage_q == GRdev) ? (dev_q | 8'h01) : dev_q;
            bit_d   = 4'd0;
            seq_d   = StWbl;
          end
        end
        StWbl: if (end_phase) seq_d = StWbh;
        StWbh: begin
          if (end_phase) begin
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_q + 4'd1;
            if (bit_q >= 4'd7) begin
              poll_d = 8'd0;
              seq_d  = StAkl;
            end else begin
              seq_d = StWbl;
            end
          end
        end
        StAkl: if (end_phase) seq_d = StAkh;
        StAkh: begin
          if (!phase_last) begin
            phase_d = phase_inc[7:0];
          end else if (sda_in_i) begin
            // Still no acknowledge: count it, or give up and restart.
            if (poll_q >= ack_limit_q) begin
              phase_d   = 8'd0;
              restart_d = 1'b1;
              seq_d     = StSpa;
            end else begin
              poll_d = poll_q + 8'd1;
            end
          end else begin
            phase_d = 8'd0;
            bit_d   = 4'd0;
            case (stage_q)
              GDev: begin
                stage_d = GAddr;
                shift_d = addr_q;
                seq_d   = StWbl;
              end
              GAddr: begin
                if (rtype_q) begin
                  stage_d = GRdev;
                  seq_d   = StStc;
                end else begin
                  stage_d = GData;
                  shift_d = wr_data_i;
                  taken   = 1'b1;
                  seq_d   = StWbl;
                end
              end
              GData: begin
                left_d = left_dec;
                if (left_dec == '0) begin
                  restart_d = 1'b0;
                  seq_d     = StSpa;
                end else begin
                  shift_d = wr_data_i;
                  taken   = 1'b1;
                  seq_d   = StWbl;
                end
              end
              default: begin
                stage_d = GRead;
                shift_d = 8'd0;
                seq_d   = StRbl;
              end
            endcase
          end
        end
        StRbl: if (end_phase) seq_d = StRbh;
        StRbh: begin
          if (end_phase) begin
            shift_d = {shift_q[6:0], sda_in_i};
            bit_d   = bit_q + 4'd1;
            if (bit_q >= 4'd7) begin
              rdv   = 1'b1;
              rdl   = (left_q <= CntW'(1));
              seq_d = StMal;
            end else begin
              seq_d = StRbl;
            end
          end
        end
        StMal: if (end_phase) seq_d = StMah;
        StMah: begin
          if (end_phase) begin
            left_d = left_dec;
            if (left_dec == '0) begin
              restart_d = 1'b0;
              seq_d     = StSpa;
            end else begin
              bit_d   = 4'd0;
              shift_d = 8'd0;
              seq_d   = StRbl;
            end
          end
        end
        StSpa: if (end_phase) seq_d = StSpb;
        StSpb: if (end_phase) seq_d = StSpc;
        StSpc: begin
          if (end_phase) begin
            if (restart_q) begin
              restart_d = 1'b0;
              stage_d   = GDev;
              left_d    = orig_q;
              poll_d    = 8'd0;
              bit_d     = 4'd0;
              seq_d     = StStc;
            end else if (!rtype_q && wait_ticks_q != 16'd0) begin
              wait_d = 16'd0;
              seq_d  = StWait;
            end else begin
              done  = 1'b1;
              seq_d = StIdle;
            end
          end
        end
        StWait: begin
          wait_d = wait_inc;
          if (wait_inc >= wait_ticks_q) begin
            wait_d = 16'd0;
            done   = 1'b1;
            seq_d  = StIdle;
          end
        end
        default: ;
      endcase
    end
  end

  // Bus levels follow the state after the step.
  assign mack = (left_d <= CntW'(1));

  always_comb begin
    res_d            = '0;
    res_d.sda_listen = 1'b0;
    unique case (seq_d) inside
      StStc: begin res_d.scl_level = 1'b0; res_d.sda_level = 1'b1; end
      StSth: begin res_d.scl_level = 1'b1; res_d.sda_level = 1'b1; end
      StStl: begin res_d.scl_level = 1'b1; res_d.sda_level = 1'b0; end
      StWbl: begin res_d.scl_level = 1'b0; res_d.sda_level = shift_d[7]; end
      StWbh: begin res_d.scl_level = 1'b1; res_d.sda_level = shift_d[7]; end
      StAkl, StRbl: begin
        res_d.scl_level  = 1'b0;
        res_d.sda_level  = 1'b1;
        res_d.sda_listen = 1'b1;
      end
      StAkh, StRbh: begin
        res_d.scl_level  = 1'b1;
        res_d.sda_level  = 1'b1;
        res_d.sda_listen = 1'b1;
      end
      StMal: begin res_d.scl_level = 1'b0; res_d.sda_level = mack; end
      StMah: begin res_d.scl_level = 1'b1; res_d.sda_level = mack; end
      StSpa: begin res_d.scl_level = 1'b0; res_d.sda_level = 1'b0; end
      StSpb: begin res_d.scl_level = 1'b1; res_d.sda_level = 1'b0; end
      default: begin res_d.scl_level = 1'b1; res_d.sda_level = 1'b1; end
    endcase
    res_d.busy_res   = (seq_d != StIdle);
    res_d.byte_taken = taken;
    res_d.rd_data    = rdv ? shift_d : 8'd0;
    res_d.rd_valid   = rdv;
    res_d.rd_last    = rdl;
    res_d.done_res   = done;
  end

  // Sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= StIdle;
      stage_q   <= GDev;
      phase_q   <= 8'd0;
      bit_q     <= 4'd0;
      shift_q   <= 8'd0;
      left_q    <= '0;
      orig_q    <= '0;
      poll_q    <= 8'd0;
      wait_q    <= 16'd0;
      rtype_q   <= 1'b0;
      dev_q     <= 8'd0;
      addr_q    <= 8'd0;
      restart_q <= 1'b0;
    end else begin
      seq_q     <= seq_d;
      stage_q   <= stage_d;
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      left_q    <= left_d;
      orig_q    <= orig_d;
      poll_q    <= poll_d;
      wait_q    <= wait_d;
      rtype_q   <= rtype_d;
      dev_q     <= dev_d;
      addr_q    <= addr_d;
      restart_q <= restart_d;
    end
  end

  // Result items leave through the output buffer.
  i2cem_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .data_i  (res_d),
    .ready_o (skid_ready),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_q)
  );

  assign scl_level_o  = res_q.scl_level;
  assign sda_level_o  = res_q.sda_level;
  assign sda_listen_o = res_q.sda_listen;
  assign busy_res_o   = res_q.busy_res;
  assign byte_taken_o = res_q.byte_taken;
  assign rd_data_o    = res_q.rd_data;
  assign rd_valid_o   = res_q.rd_valid;
  assign rd_last_o    = res_q.rd_last;
  assign done_res_o   = res_q.done_res;

`ifndef SYNTHESIS
  // The input side only stalls while a result is waiting downstream.
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // A request taken in idle always opens with the start condition.
  a_req_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && seq_q == StIdle && req_valid_i) |=> (seq_q == StStc))
    else $error("request in idle did not start a transaction");

  // The bit counter never runs past one byte.
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'd8)
    else $error("bit index out of range");
`endif

endmodule

// File: tb/tb_i2c_eeprom_master_sequencer.sv
// Self-checking testbench for the I2C EEPROM master sequencer: timing ticks are fed in
// through a queue, the expected bus levels come from a tick-by-tick model of the sequencer.
// Depends on i2cem_pkg and the i2c_eeprom_master_sequencer RTL.
`timescale 1ns / 100ps

module tb_i2c_eeprom_master_sequencer;
  import i2cem_pkg::*;

  localparam int   MaxBurst      = 256;
  localparam int   WatchdogLimit = 4000;
  localparam int   LongHold      = 80;
  localparam int   ReportCap     = 40;
  localparam int   BusyTicks     = 20;
  localparam int   TailBatch     = 16;
  localparam logic ReqWrite      = 1'b0;
  localparam logic ReqRead       = 1'b1;

  // One input item: a timing tick with an optional request and the sampled SDA level
  typedef struct packed {
    logic       req_valid;
    logic       req_type;
    logic [7:0] dev_sel;
    logic [7:0] word_addr;
    logic [8:0] byte_count;
    logic [7:0] wr_data;
    logic       sda_in;
  } tick_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START_PREP, ST_START_HIGH, ST_START_LOW, ST_BIT_LOW, ST_BIT_HIGH,
    ST_ACK_LOW, ST_ACK_HIGH, ST_RD_LOW, ST_RD_HIGH, ST_MACK_LOW, ST_MACK_HIGH,
    ST_STOP_LOW, ST_STOP_CLK, ST_STOP_RISE, ST_WRITE_WAIT
  } bus_state_e;

  typedef enum logic [2:0] {
    SEG_CTRL, SEG_ADDR, SEG_DATA, SEG_RCTRL, SEG_READ
  } segment_e;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [1:0]  cfg_idx_i    = CfgPhaseTicks;
  logic [15:0] cfg_wdata_i  = '0;
  logic        in_valid_i   = 1'b0;
  logic        req_valid_i  = 1'b0;
  logic        req_type_i   = ReqWrite;
  logic [7:0]  dev_sel_i    = '0;
  logic [7:0]  word_addr_i  = '0;
  logic [8:0]  byte_count_i = '0;
  logic [7:0]  wr_data_i    = '0;
  logic        sda_in_i     = 1'b0;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        scl_level_o;
  logic        sda_level_o;
  logic        sda_listen_o;
  logic        busy_res_o;
  logic        byte_taken_o;
  logic [7:0]  rd_data_o;
  logic        rd_valid_o;
  logic        rd_last_o;
  logic        done_res_o;

  i2c_eeprom_master_sequencer #(
    .MAX_BURST(MaxBurst)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_valid_i  (req_valid_i),
    .req_type_i   (req_type_i),
    .dev_sel_i    (dev_sel_i),
    .word_addr_i  (word_addr_i),
    .byte_count_i (byte_count_i),
    .wr_data_i    (wr_data_i),
    .sda_in_i     (sda_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_level_o  (scl_level_o),
    .sda_level_o  (sda_level_o),
    .sda_listen_o (sda_listen_o),
    .busy_res_o   (busy_res_o),
    .byte_taken_o (byte_taken_o),
    .rd_data_o    (rd_data_o),
    .rd_valid_o   (rd_valid_o),
    .rd_last_o    (rd_last_o),
    .done_res_o   (done_res_o)
  );

  // 10 ns clock.
  always #5 clk_i = ~clk_i;

  // Configuration as the sequencer currently holds it.
  logic [7:0]  cfg_phase      = PhaseTicksRst;
  logic [7:0]  cfg_poll_limit = AckPollLimitRst;
  logic [15:0] cfg_wait       = WriteWaitRst;

  // Model state of the sequencer.
  bus_state_e  bus_state     = ST_IDLE;
  segment_e    segment       = SEG_CTRL;
  logic [7:0]  phase_cnt     = '0;
  logic [3:0]  bit_cnt       = '0;
  logic [7:0]  shift_reg     = '0;
  logic [8:0]  left_cnt      = '0;
  logic [8:0]  burst_len     = '0;
  logic [7:0]  poll_cnt      = '0;
  logic [15:0] wait_cnt      = '0;
  logic        req_is_read   = 1'b0;
  logic [7:0]  req_dev       = '0;
  logic [7:0]  req_addr      = '0;
  logic        retry_pending = 1'b0;

  tick_t       tick_q[$];
  result_t     bus_levels_q[$];
  int          error_cnt      = 0;
  int          quiet_cycles   = 0;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;
  bit          long_hold_req  = 1'b0;
  bit          tick_accepted  = 1'b0;

  // Advances the sequencer model by one tick and returns the bus levels it then shows.
  function automatic result_t advance_bus(input tick_t t);
    result_t    r;
    int         pt;
    logic       phase_end;
    logic [8:0] len;
    pt        = (cfg_phase == 8'd0) ? 1 : int'(cfg_phase);
    phase_end = 1'b0;
    r         = '0;

    // The phase counter runs everywhere except while idle, waiting or polling for ACK.
    if (bus_state != ST_IDLE && bus_state != ST_WRITE_WAIT && bus_state != ST_ACK_HIGH) begin
      if (int'(phase_cnt) + 1 >= pt) begin
        phase_cnt = '0;
        phase_end = 1'b1;
      end else begin
        phase_cnt = phase_cnt + 8'd1;
      end
    end

    case (bus_state)
      ST_IDLE: begin
        if (t.req_valid) begin
          len = (t.byte_count == 9'd0) ? 9'd1 : t.byte_count;
          if (len > 9'(MaxBurst)) len = 9'(MaxBurst);
          req_is_read   = (t.req_type == ReqRead);
          req_dev       = t.dev_sel;
          req_addr      = t.word_addr;
          burst_len     = len;
          left_cnt      = len;
          segment       = SEG_CTRL;
          retry_pending = 1'b0;
          phase_cnt     = '0;
          poll_cnt      = '0;
          bit_cnt       = '0;
          bus_state     = ST_START_PREP;
        end
      end
      ST_START_PREP: if (phase_end) bus_state = ST_START_HIGH;
      ST_START_HIGH: if (phase_end) bus_state = ST_START_LOW;
      ST_START_LOW: begin
        if (phase_end) begin
          shift_reg = (segment == SEG_RCTRL) ? (req_dev | 8'h01) : req_dev;
          bit_cnt   = '0;
          bus_state = ST_BIT_LOW;
        end
      end
      ST_BIT_LOW: if (phase_end) bus_state = ST_BIT_HIGH;
      ST_BIT_HIGH: begin
        if (phase_end) begin
          shift_reg = {shift_reg[6:0], 1'b0};
          bit_cnt   = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            poll_cnt  = '0;
            bus_state = ST_ACK_LOW;
          end else begin
            bus_state = ST_BIT_LOW;
          end
        end
      end
      ST_ACK_LOW: if (phase_end) bus_state = ST_ACK_HIGH;
      ST_ACK_HIGH: begin
        // SDA is polled on every tick once the high phase has elapsed.
        if (int'(phase_cnt) + 1 < pt) begin
          phase_cnt = phase_cnt + 8'd1;
        end else if (t.sda_in) begin
          if (poll_cnt >= cfg_poll_limit) begin
            phase_cnt     = '0;
            retry_pending = 1'b1;
            bus_state     = ST_STOP_LOW;
          end else begin
            poll_cnt = poll_cnt + 8'd1;
          end
        end else begin
          phase_cnt = '0;
          bit_cnt   = '0;
          case (segment)
            SEG_CTRL: begin
              segment   = SEG_ADDR;
              shift_reg = req_addr;
              bus_state = ST_BIT_LOW;
            end
            SEG_ADDR: begin
              if (req_is_read) begin
                segment   = SEG_RCTRL;
                bus_state = ST_START_PREP;
              end else begin
                segment      = SEG_DATA;
                shift_reg    = t.wr_data;
                r.byte_taken = 1'b1;
                bus_state    = ST_BIT_LOW;
              end
            end
            SEG_DATA: begin
              if (left_cnt > 9'd0) left_cnt = left_cnt - 9'd1;
              if (left_cnt == 9'd0) begin
                retry_pending = 1'b0;
                bus_state     = ST_STOP_LOW;
              end else begin
                shift_reg    = t.wr_data;
                r.byte_taken = 1'b1;
                bus_state    = ST_BIT_LOW;
              end
            end
            default: begin
              segment   = SEG_READ;
              shift_reg = '0;
              bus_state = ST_RD_LOW;
            end
          endcase
        end
      end
      ST_RD_LOW: if (phase_end) bus_state = ST_RD_HIGH;
      ST_RD_HIGH: begin
        if (phase_end) begin
          shift_reg = {shift_reg[6:0], t.sda_in};
          bit_cnt   = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            r.rd_valid = 1'b1;
            r.rd_data  = shift_reg;
            r.rd_last  = (left_cnt <= 9'd1);
            bus_state  = ST_MACK_LOW;
          end else begin
            bus_state = ST_RD_LOW;
          end
        end
      end
      ST_MACK_LOW: if (phase_end) bus_state = ST_MACK_HIGH;
      ST_MACK_HIGH: begin
        if (phase_end) begin
          if (left_cnt > 9'd0) left_cnt = left_cnt - 9'd1;
          if (left_cnt == 9'd0) begin
            retry_pending = 1'b0;
            bus_state     = ST_STOP_LOW;
          end else begin
            bit_cnt   = '0;
            shift_reg = '0;
            bus_state = ST_RD_LOW;
          end
        end
      end
      ST_STOP_LOW: if (phase_end) bus_state = ST_STOP_CLK;
      ST_STOP_CLK: if (phase_end) bus_state = ST_STOP_RISE;
      ST_STOP_RISE: begin
        // After the stop: restart on a lost ACK, else the write wait or done.
        if (phase_end) begin
          if (retry_pending) begin
            retry_pending = 1'b0;
            segment       = SEG_CTRL;
            left_cnt      = burst_len;
            poll_cnt      = '0;
            bit_cnt       = '0;
            bus_state     = ST_START_PREP;
          end else if (!req_is_read && cfg_wait != 16'd0) begin
            wait_cnt  = '0;
            bus_state = ST_WRITE_WAIT;
          end else begin
            r.done_res = 1'b1;
            bus_state  = ST_IDLE;
          end
        end
      end
      ST_WRITE_WAIT: begin
        wait_cnt = wait_cnt + 16'd1;
        if (wait_cnt >= cfg_wait) begin
          wait_cnt   = '0;
          r.done_res = 1'b1;
          bus_state  = ST_IDLE;
        end
      end
      default: ;
    endcase

    // Bus levels of the state reached.
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    case (bus_state) inside
      ST_START_PREP: r.scl_level = 1'b0;
      ST_START_LOW:  r.sda_level = 1'b0;
      ST_BIT_LOW: begin
        r.scl_level = 1'b0;
        r.sda_level = shift_reg[7];
      end
      ST_BIT_HIGH:   r.sda_level = shift_reg[7];
      ST_ACK_LOW, ST_RD_LOW: begin
        r.scl_level  = 1'b0;
        r.sda_listen = 1'b1;
      end
      ST_ACK_HIGH, ST_RD_HIGH: r.sda_listen = 1'b1;
      ST_MACK_LOW: begin
        r.scl_level = 1'b0;
        r.sda_level = (left_cnt <= 9'd1);
      end
      ST_MACK_HIGH:  r.sda_level = (left_cnt <= 9'd1);
      ST_STOP_LOW: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
      end
      ST_STOP_CLK:   r.sda_level = 1'b0;
      default: ;
    endcase
    r.busy_res = (bus_state != ST_IDLE);
    return r;
  endfunction

  // A tick with random fields; requests and high SDA samples at the given rates.
  function automatic tick_t random_tick(input int req_pct, input int one_pct);
    tick_t t;
    int    pick;
    pick        = $urandom_range(99);
    t.req_valid = ($urandom_range(99) < req_pct);
    t.req_type  = 1'($urandom_range(1));
    t.dev_sel   = 8'($urandom_range(255));
    t.word_addr = 8'($urandom_range(255));
    if (pick < 3) t.byte_count = 9'd0;
    else if (pick < 8) t.byte_count = 9'($urandom_range(16, 5));
    else t.byte_count = 9'($urandom_range(4, 1));
    t.wr_data = 8'($urandom_range(255));
    t.sda_in  = ($urandom_range(99) < one_pct);
    return t;
  endfunction

  // Compares one result item with the expected one.
  task automatic check_item(input result_t want, input result_t got);
    if (want != got) begin
      error_cnt++;
      if (error_cnt <= ReportCap)
        $display("%0t: result mismatch, expected %h, got %h", $time, want, got);
    end
  endtask

  // Waits until every queued tick has been taken and every result has come back.
  task automatic drain();
    do @(posedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || bus_levels_q.size() != 0);
  endtask

  // Feeds quiet ticks until the model is back in idle.
  task automatic finish_transfer();
    int tail_pct;
    tail_pct = (cfg_poll_limit >= 8'd16) ? 50 : 0;
    drain();
    while (bus_state != ST_IDLE) begin
      repeat (TailBatch) tick_q.push_back(random_tick(0, tail_pct));
      drain();
    end
  endtask

  // Writes all three registers; only called with nothing in flight and the model idle.
  task automatic write_registers(input logic [7:0] pt, input logic [7:0] limit,
                                 input logic [15:0] wait_ticks);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgPhaseTicks;
    cfg_wdata_i <= {8'h00, pt};
    @(negedge clk_i);
    cfg_idx_i   <= CfgAckPollLimit;
    cfg_wdata_i <= {8'h00, limit};
    @(negedge clk_i);
    cfg_idx_i   <= CfgWriteWait;
    cfg_wdata_i <= wait_ticks;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_phase      = pt;
    cfg_poll_limit = limit;
    cfg_wait       = wait_ticks;
  endtask

  // One request followed by busy ticks that carry ignored requests, then run to idle.
  task automatic request(input logic kind, input logic [7:0] dev, input logic [7:0] addr,
                         input logic [8:0] count, input bit stuck_high);
    tick_t t;
    t            = random_tick(100, 0);
    t.req_type   = kind;
    t.dev_sel    = dev;
    t.word_addr  = addr;
    t.byte_count = count;
    tick_q.push_back(t);
    repeat (BusyTicks) tick_q.push_back(random_tick(100, stuck_high ? 100 : 50));
    finish_transfer();
  endtask

  // Random ticks, optionally with a pause half way until everything has come back.
  task automatic run_random(input int n, input int one_pct, input bit pause_midway);
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain();
      tick_q.push_back(random_tick(25, one_pct));
    end
    finish_transfer();
  endtask

  // Tick driver: holds an offered item until it is taken, otherwise may leave a gap.
  always @(negedge clk_i) begin
    tick_t t;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || tick_accepted) begin
      tick_accepted = 1'b0;
      if (tick_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        t = tick_q.pop_front();
        in_valid_i   <= 1'b1;
        req_valid_i  <= t.req_valid;
        req_type_i   <= t.req_type;
        dev_sel_i    <= t.dev_sel;
        word_addr_i  <= t.word_addr;
        byte_count_i <= t.byte_count;
        wr_data_i    <= t.wr_data;
        sda_in_i     <= t.sda_in;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off when asked for.
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      hold_left     = LongHold;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts each accepted tick and checks each accepted result item.
  always @(posedge clk_i) begin
    tick_t   t;
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        t = '{req_valid: req_valid_i, req_type: req_type_i, dev_sel: dev_sel_i,
              word_addr: word_addr_i, byte_count: byte_count_i, wr_data: wr_data_i,
              sda_in: sda_in_i};
        bus_levels_q.push_back(advance_bus(t));
        tick_accepted = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        got = '{scl_level: scl_level_o, sda_level: sda_level_o, sda_listen: sda_listen_o,
                busy_res: busy_res_o, byte_taken: byte_taken_o, rd_data: rd_data_o,
                rd_valid: rd_valid_o, rd_last: rd_last_o, done_res: done_res_o};
        if (bus_levels_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= ReportCap)
            $display("%0t: result item with none expected, got %h", $time, got);
        end else begin
          want = bus_levels_q.pop_front();
          check_item(want, got);
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The first transfer runs on the reset configuration.
    request(ReqRead, 8'hA0, 8'h00, 9'd1, 1'b0);
    write_registers(8'd1, 8'd250, 16'd3);
    // A zero count is sent as one byte.
    request(ReqWrite, 8'hFF, 8'hFF, 9'd0, 1'b0);
    request(ReqRead, 8'h00, 8'h80, 9'd3, 1'b0);
    request(ReqWrite, 8'hA2, 8'h00, 9'd2, 1'b0);
    // SDA held high through the first acknowledge forces a stop and a restart.
    write_registers(8'd1, 8'd1, 16'd0);
    request(ReqWrite, 8'hA0, 8'h20, 9'd2, 1'b1);
    request(ReqRead, 8'hA0, 8'h30, 9'd2, 1'b1);
    // Zero phase length acts as one; zero poll limit; a short write wait.
    write_registers(8'd0, 8'd0, 16'd40);
    request(ReqWrite, 8'hA4, 8'h40, 9'd1, 1'b1);
    request(ReqRead, 8'hA5, 8'h41, 9'd2, 1'b0);

    // Random part, one phase per configuration and idling pattern.
    write_registers(8'd1, 8'd250, 16'd0);
    run_random(100, 30, 1'b0);

    send_gap_pct = 55;
    write_registers(8'd2, 8'd2, 16'd10);
    run_random(100, 30, 1'b1);

    send_gap_pct   = 0;
    recv_stall_pct = 55;
    write_registers(8'd3, 8'd1, 16'd0);
    long_hold_req = 1'b1;
    run_random(100, 40, 1'b0);

    send_gap_pct   = 13;
    recv_stall_pct = 13;
    write_registers(8'($urandom_range(4, 1)), 8'($urandom_range(8, 1)),
                    16'($urandom_range(20, 0)));
    run_random(100, 35, 1'b0);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_registers(8'($urandom_range(4, 1)), 8'($urandom_range(255, 1)),
                    16'($urandom_range(20, 0)));
    run_random(100, 20, 1'b0);

    drain();
    repeat (10) @(posedge clk_i);
    if (error_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
